@@ sv/frpq_pkg.sv @@
// Package for the fixed-radius proximity query block.
// Holds the item structs, function codes, state type and default sizes.
// Depends on nothing; every module of the block imports it.
package frpq_pkg;

   localparam int COORD_W           = 24;
   localparam int RADIUS_W          = 24;
   localparam int LIMIT_W           = 2 * RADIUS_W;
   localparam int DIFF_W            = COORD_W + 1;
   localparam int SQ_W              = 2 * DIFF_W;
   localparam int SUM_W             = SQ_W + 2;
   localparam int MAX_SEEDS_DEFAULT = 256;

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]                 func;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
   } req_item_type;

   typedef struct packed {
      logic hit;
      logic status;
   } rsp_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } seed_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

@@ sv/fixed_radius_proximity_query.sv @@
// Fixed-radius proximity query: seed store in one synchronous memory plus a
// pipelined distance check that walks the stored seeds one per cycle.
// Depends on frpq_pkg.
//
// Usage: an item is taken when start is high and busy is low. Its func field
// clears the seed store, loads one seed, or asks whether the query point lies
// within the radius of any stored seed. Each item gives exactly one result,
// shown on rsp_item for a single cycle while rsp_valid is high; the receiver
// cannot stall it. The radius is written through csr_valid/csr_data (always
// ready) only while the block is idle, a user rule the block does not enforce.
// Timing: clear, load, unused codes and queries that cannot hit (zero radius
// or empty store) answer in the cycle after acceptance and busy stays low.
// A query reads the seed memory at one address per cycle through its single
// read port; each seed passes the read, absolute and square registers, its
// sum is compared and the result registered. A hit answers on the first near
// seed, a miss after the last loaded seed, and busy is high until it answers.
// Reset empties the store and sets the radius to zero; no clearing pass is
// needed because only loaded entries are ever used in a distance check.
module fixed_radius_proximity_query #(
   parameter int MAX_SEEDS = frpq_pkg::MAX_SEEDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  frpq_pkg::req_item_type          req_item,
   output logic                            rsp_valid,
   output frpq_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [frpq_pkg::RADIUS_W-1:0]   csr_data
);
   import frpq_pkg::*;

   localparam int ADDR_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CNT_W  = $clog2(MAX_SEEDS + 1);

   seed_type                   seed_mem [MAX_SEEDS];
   seed_type                   rd_data_ff;
   logic [ADDR_W-1:0]          rd_addr;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           issue_ff, issue_in;
   logic [RADIUS_W-1:0]        radius_ff;
   logic [LIMIT_W-1:0]         limit_ff;
   seed_type                   qry_ff, qry_in;

   logic                       vld_rd_ff, vld_rd_in;
   logic                       vld_abs_ff, vld_abs_in;
   logic                       vld_sq_ff, vld_sq_in;
   logic [DIFF_W-1:0]          abs_x_ff, abs_y_ff, abs_z_ff;
   logic [SQ_W-1:0]            sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [DIFF_W-1:0]   diff_x, diff_y, diff_z;
   logic [SUM_W-1:0]           dist_sum;
   logic                       near;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic                       rsp_status_ff, rsp_status_in;

   logic                       accept;
   logic                       issuing;
   logic                       mem_we;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = '{hit: rsp_hit_ff, status: rsp_status_ff};
   assign issuing   = (state_ff == ST_WALK) && (issue_ff < count_ff);
   assign rd_addr   = issue_ff[ADDR_W-1:0];
   assign mem_we    = accept && (req_item.func == FUNC_LOAD)
                      && (count_ff < CNT_W'(MAX_SEEDS));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seed_mem[count_ff[ADDR_W-1:0]] <= '{x: req_item.pos_x, y: req_item.pos_y,
                                            z: req_item.pos_z};
      end
      rd_data_ff <= seed_mem[rd_addr];
   end

   assign diff_x = {qry_ff.x[COORD_W-1], qry_ff.x} - {rd_data_ff.x[COORD_W-1], rd_data_ff.x};
   assign diff_y = {qry_ff.y[COORD_W-1], qry_ff.y} - {rd_data_ff.y[COORD_W-1], rd_data_ff.y};
   assign diff_z = {qry_ff.z[COORD_W-1], qry_ff.z} - {rd_data_ff.z[COORD_W-1], rd_data_ff.z};

   assign dist_sum = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   assign near     = vld_sq_ff && (dist_sum <= SUM_W'(limit_ff));

   always_ff @(posedge clock) begin
      abs_x_ff <= diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
      abs_y_ff <= diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
      abs_z_ff <= diff_z[DIFF_W-1] ? DIFF_W'(-diff_z) : DIFF_W'(diff_z);
      sq_x_ff  <= SQ_W'(abs_x_ff) * SQ_W'(abs_x_ff);
      sq_y_ff  <= SQ_W'(abs_y_ff) * SQ_W'(abs_y_ff);
      sq_z_ff  <= SQ_W'(abs_z_ff) * SQ_W'(abs_z_ff);
      limit_ff <= LIMIT_W'(radius_ff) * LIMIT_W'(radius_ff);
      qry_ff   <= qry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         vld_rd_ff    <= 1'b0;
         vld_abs_ff   <= 1'b0;
         vld_sq_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         vld_rd_ff    <= vld_rd_in;
         vld_abs_ff   <= vld_abs_in;
         vld_sq_ff    <= vld_sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      qry_in        = qry_ff;
      vld_rd_in     = issuing;
      vld_abs_in    = vld_rd_ff;
      vld_sq_in     = vld_abs_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_status_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            vld_rd_in  = 1'b0;
            vld_abs_in = 1'b0;
            vld_sq_in  = 1'b0;
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_item.func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_LOAD: begin
                     if (count_ff < CNT_W'(MAX_SEEDS)) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  FUNC_QUERY: begin
                     if ((radius_ff != '0) && (count_ff != '0)) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_WALK;
                        issue_in     = '0;
                        qry_in       = '{x: req_item.pos_x, y: req_item.pos_y,
                                         z: req_item.pos_z};
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (issuing) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (near || (!issuing && !vld_rd_ff && !vld_abs_ff && vld_sq_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = near;
               state_in     = ST_IDLE;
               vld_rd_in    = 1'b0;
               vld_abs_in   = 1'b0;
               vld_sq_in    = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SEEDS))
      else $error("Seed count exceeds the store depth.");

   assert property (@(posedge clock) disable iff (reset)
      issuing |-> (issue_ff < count_ff) && (count_ff != '0))
      else $error("Seed read issued beyond the loaded entries.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_status_ff))
      else $error("Result reports both a hit and a dropped load.");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.func == FUNC_QUERY) && (radius_ff != '0) && (count_ff != '0))
      |=> busy && !rsp_valid_ff)
      else $error("Query walk did not start after acceptance.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && (state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("Query walk ended without a result.");
`endif

endmodule

@@ bench/tb_fixed_radius_proximity_query.sv @@
// Testbench for fixed_radius_proximity_query: directed and random clear, load and query items,
// checked against a scoreboard class that predicts every result from its own seed store.
// Depends on frpq_pkg and the fixed_radius_proximity_query RTL.
module tb_fixed_radius_proximity_query;
   import frpq_pkg::*;

   localparam int MAX_SEEDS = MAX_SEEDS_DEFAULT;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT = 1500000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

   class proximity_scoreboard;
      seed_type seeds[MAX_SEEDS];
      int unsigned seed_count;
      logic [RADIUS_W-1:0] radius = '0;
      rsp_item_type expected_answers[$];
      int errors;
      int n_clear, n_load, n_drop, n_query, n_hit, n_unused, n_radius;

      function void set_radius(logic [RADIUS_W-1:0] value);
         radius = value;
         n_radius++;
      endfunction

      function longint axis_square(logic signed [COORD_W-1:0] a,
                                   logic signed [COORD_W-1:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         return d * d;
      endfunction

      function bit point_near_seed(req_item_type it);
         longint limit;
         longint dsq;
         if (radius == 0) return 1'b0;
         limit = longint'(radius) * longint'(radius);
         for (int i = 0; i < seed_count; i++) begin
            dsq = axis_square(it.pos_x, seeds[i].x) + axis_square(it.pos_y, seeds[i].y)
                + axis_square(it.pos_z, seeds[i].z);
            if (dsq <= limit) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(req_item_type it);
         rsp_item_type answer;
         answer = '0;
         case (it.func)
            FUNC_CLEAR: begin
               seed_count = 0;
               n_clear++;
            end
            FUNC_LOAD: begin
               n_load++;
               if (seed_count >= MAX_SEEDS) begin
                  answer.status = 1'b1;
                  n_drop++;
               end else begin
                  seeds[seed_count] = '{x: it.pos_x, y: it.pos_y, z: it.pos_z};
                  seed_count++;
               end
            end
            FUNC_QUERY: begin
               answer.hit = point_near_seed(it);
               n_query++;
               if (answer.hit) n_hit++;
            end
            default: n_unused++;
         endcase
         expected_answers.push_back(answer);
      endfunction

      function void check_answer(rsp_item_type got);
         rsp_item_type want;
         if (expected_answers.size() == 0) begin
            $display("%0t: result with none expected: hit %0b status %0b",
                     $time, got.hit, got.status);
            errors++;
            return;
         end
         want = expected_answers.pop_front();
         if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, got.hit);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0b, actual %0b",
                     $time, want.status, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_item_type req_item;
   logic rsp_valid;
   rsp_item_type rsp_item;
   logic csr_valid;
   logic csr_ready;
   logic [RADIUS_W-1:0] csr_data;

   proximity_scoreboard sb = new();
   int cycles = 0;
   int items_sent = 0;
   int idle_pct = 0;
   int unsigned cur_radius = 0;
   req_item_type seed_log[$];

   fixed_radius_proximity_query #(.MAX_SEEDS(MAX_SEEDS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_item);
         if (rsp_valid) sb.check_answer(rsp_item);
         if (csr_valid && csr_ready) sb.set_radius(csr_data);
      end
   end

   function automatic req_item_type make_item(logic [1:0] f, logic [COORD_W-1:0] x,
                                              logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
      req_item_type it;
      it.func = f;
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      return it;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(19))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [RADIUS_W-1:0] pick_radius();
      case ($urandom_range(9))
         0: return '0;
         1: return RADIUS_MAX;
         2, 3: return RADIUS_W'($urandom_range(1, 1023));
         4, 5, 6: return RADIUS_W'($urandom_range(1024, 65535));
         default: return RADIUS_W'($urandom);
      endcase
   endfunction

   function automatic req_item_type query_near(req_item_type s, int r);
      int span;
      int dx, dy, dz;
      span = (r > 4194304) ? 4194304 : r;
      dy = 0;
      dz = 0;
      case ($urandom_range(9))
         0: dx = $urandom_range(1) ? r : -r;
         1: dx = $urandom_range(1) ? r + 1 : -r - 1;
         default: begin
            dx = $urandom_range(2 * span) - span;
            dy = $urandom_range(2 * span) - span;
            dz = $urandom_range(2 * span) - span;
         end
      endcase
      return make_item(FUNC_QUERY, COORD_W'(int'(s.pos_x) + dx),
                       COORD_W'(int'(s.pos_y) + dy), COORD_W'(int'(s.pos_z) + dz));
   endfunction

   task automatic sender_pause();
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_item <= make_item(2'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                               COORD_W'($urandom));
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic drive_item(req_item_type it);
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      items_sent++;
      if (it.func == FUNC_CLEAR) seed_log.delete();
      if (it.func == FUNC_LOAD) seed_log.push_back(it);
      sender_pause();
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_radius(logic [RADIUS_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_radius = 32'(value);
   endtask

   task automatic run_directed();
      drive_item(make_item(FUNC_QUERY, 0, 0, 0));
      write_radius(256);
      drive_item(make_item(FUNC_QUERY, 5, 5, 5));
      drive_item(make_item(FUNC_LOAD, 0, 0, 0));
      drive_item(make_item(FUNC_LOAD, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
      drive_item(make_item(FUNC_LOAD, 24'h800000, 24'h800000, 24'h800000));
      drive_item(make_item(FUNC_QUERY, 256, 0, 0));
      drive_item(make_item(FUNC_QUERY, 0, 24'hFFFEFF, 0));
      drive_item(make_item(FUNC_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFEFF));
      drive_item(make_item(FUNC_QUERY, 24'h800064, 24'h800000, 24'h800000));
      drive_item(make_item(FUNC_UNUSED, 24'h7FFFFF, 24'h800000, 24'hFFFFFF));
      write_radius(RADIUS_MAX);
      drive_item(make_item(FUNC_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
      drive_item(make_item(FUNC_QUERY, 24'h800000, 24'h7FFFFF, 24'h800000));
      write_radius(0);
      drive_item(make_item(FUNC_QUERY, 0, 0, 0));
      write_radius(1);
      drive_item(make_item(FUNC_QUERY, 1, 0, 0));
      drive_item(make_item(FUNC_QUERY, 1, 1, 0));
      drive_item(make_item(FUNC_CLEAR, 24'hFFFFFF, 24'h800000, 24'h7FFFFF));
      drive_item(make_item(FUNC_QUERY, 0, 0, 0));
      drive_item(make_item(FUNC_UNUSED, 0, 0, 0));
   endtask

   task automatic run_round(bit fill);
      int n_load;
      int n_query;
      req_item_type it;
      write_radius(pick_radius());
      if (!fill && $urandom_range(99) < 15) begin
         repeat (8) drive_item(make_item(2'($urandom), rand_coord(), rand_coord(),
                                         rand_coord()));
         return;
      end
      if (fill) begin
         drive_item(make_item(FUNC_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                              COORD_W'($urandom)));
         n_load = MAX_SEEDS + $urandom_range(1, 3);
         n_query = $urandom_range(3, 6);
      end else begin
         if ($urandom_range(9) < 7)
            drive_item(make_item(FUNC_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                                 COORD_W'($urandom)));
         n_load = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         n_query = $urandom_range(4, 16);
      end
      repeat (n_load) begin
         drive_item(make_item(FUNC_LOAD, rand_coord(), rand_coord(), rand_coord()));
         if ($urandom_range(19) == 0)
            drive_item(make_item(FUNC_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
                                 COORD_W'($urandom)));
      end
      repeat (n_query) begin
         if (seed_log.size() != 0 && $urandom_range(3) != 0)
            it = query_near(seed_log[$urandom_range(seed_log.size() - 1)], cur_radius);
         else
            it = make_item(FUNC_QUERY, rand_coord(), rand_coord(), rand_coord());
         drive_item(it);
      end
   endtask

   task automatic run_random();
      int phase_pct[4] = '{0, 49, 0, 34};
      int first_item;
      int phase;
      bit fill;
      first_item = items_sent;
      fill = 1'b1;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         phase = ((items_sent - first_item) * 4) / RANDOM_ITEMS;
         idle_pct = phase_pct[(phase > 3) ? 3 : phase];
         run_round(fill);
         fill = ($urandom_range(99) < 4);
      end
      idle_pct = 0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      drain();
      repeat (MAX_SEEDS + 8) @(posedge clock);
      $display("Ran %0d items: %0d queries with %0d hits, %0d loads with %0d dropped,",
               items_sent, sb.n_query, sb.n_hit, sb.n_load, sb.n_drop);
      $display("%0d clears, %0d unused codes and %0d radius writes; %0d mismatches.",
               sb.n_clear, sb.n_unused, sb.n_radius, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ fixed_radius_proximity_query.f @@
sv/frpq_pkg.sv
sv/fixed_radius_proximity_query.sv
bench/tb_fixed_radius_proximity_query.sv
